@@ rtl/core/sfla_pkg.sv @@
// Shared port widths, opcodes and status codes of the segregated free list allocator.
`timescale 1ns / 1ps
package sfla_pkg;
	localparam int OP_W     = 2;
	localparam int REQ_W    = 20;
	localparam int ADDR_W   = 18;
	localparam int STATUS_W = 3;
	localparam int BYTES_W  = 19;
	localparam int CFG_W    = 7;

	localparam logic [CFG_W-1:0] CFG_POOL_RESET = 7'd64;

	typedef logic [OP_W-1:0]     opcode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam opcode_t OP_ALLOC    = 2'd0;
	localparam opcode_t OP_FREE     = 2'd1;
	localparam opcode_t OP_CLEAR    = 2'd2;
	localparam opcode_t OP_RESERVED = 2'd3;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_ZERO_SIZE = 3'd1;
	localparam status_t ST_TOO_LARGE = 3'd2;
	localparam status_t ST_EXHAUSTED = 3'd3;
	localparam status_t ST_BAD_ADDR  = 3'd4;
	localparam status_t ST_NULL_FREE = 3'd5;
endpackage

@@ rtl/core/sfla_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sfla_ram #(
	parameter int WIDTH = 14,
	parameter int DEPTH = 8192
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ rtl/core/segregated_free_list_allocator.sv @@
// Top level of the segregated free list allocator: control sequencer, list heads and memories.
`timescale 1ns / 1ps
// Power-of-two slab allocator over POOL_PAGES pages. Link words and the stored request size
// (with a live flag) sit in three one-read, one-write RAMs; each request is a short sequence
// of read, then modify and write back. Clear, requests rejected on their size or address and
// the unused opcode go straight to the result; an allocate from a non-empty list reads the
// head's link and then pops the head; an allocate that carves a page first writes all its
// PAGE_SIZE >> MIN_BLOCK_SHIFT slots (128 by default), one slot per cycle through the RAM
// write ports; a free reads the block's live flag and, if it is set, pushes the block onto an
// empty list or walks back from the tail one list element at a time, each step waiting on one
// RAM read, before linking it in. A new request is taken while the previous result still
// waits on the output. No clearing pass after reset: live flags are trusted only inside pages
// carved since the last clear, and a carve rewrites the flags of its whole page.
module segregated_free_list_allocator #(
	parameter int POOL_PAGES      = 64,
	parameter int NUM_CLASSES     = 8,
	parameter int PAGE_SIZE       = 4096,
	parameter int HEADER_BYTES    = 16,
	parameter int MIN_BLOCK_SHIFT = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [sfla_pkg::CFG_W-1:0]    cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  sfla_pkg::opcode_t         opcode,
	input  logic [sfla_pkg::REQ_W-1:0]    request_size,
	input  logic [sfla_pkg::ADDR_W-1:0]   payload_address,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [sfla_pkg::ADDR_W-1:0]   result_address,
	output sfla_pkg::status_t         status,
	output logic [sfla_pkg::BYTES_W-1:0]  allocated_bytes,
	output logic [sfla_pkg::BYTES_W-1:0]  pool_bytes_used
);
	import sfla_pkg::*;

	localparam int SPP        = PAGE_SIZE >> MIN_BLOCK_SHIFT;
	localparam int SPP_LG     = $clog2(SPP);
	localparam int PAGE_LG    = $clog2(PAGE_SIZE);
	localparam int POOL_SLOTS = POOL_PAGES * SPP;
	localparam int SLOT_W     = $clog2(POOL_SLOTS);
	localparam int LINK_W     = SLOT_W + 1;
	localparam int PG_W       = $clog2(POOL_PAGES + 1);
	localparam int SIZE_W     = PAGE_LG;
	localparam int CLS_W      = $clog2(NUM_CLASSES + 1);
	localparam int CLS_IW     = NUM_CLASSES > 1 ? $clog2(NUM_CLASSES) : 1;
	localparam int MAX_CLS    = PAGE_LG - MIN_BLOCK_SHIFT;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_SLOTS);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_CARVE     = 4'd1;
	localparam logic [3:0] S_POP_RD    = 4'd2;
	localparam logic [3:0] S_POP_WR    = 4'd3;
	localparam logic [3:0] S_FREE_CHK  = 4'd4;
	localparam logic [3:0] S_WALK      = 4'd5;
	localparam logic [3:0] S_WALK_PREV = 4'd6;
	localparam logic [3:0] S_INS1      = 4'd7;
	localparam logic [3:0] S_INS2      = 4'd8;
	localparam logic [3:0] S_PUSH1     = 4'd9;
	localparam logic [3:0] S_PUSH2     = 4'd10;
	localparam logic [3:0] S_DONE      = 4'd11;

	function automatic logic [CLS_W-1:0] class_of(input logic [REQ_W:0] need);
		int cnt;
		cnt = 0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (32'(need) > (32'd1 << (MIN_BLOCK_SHIFT + i))) begin
				cnt = cnt + 1;
			end
		end
		if (cnt > MAX_CLS) begin
			cnt = NUM_CLASSES;
		end
		return CLS_W'(cnt);
	endfunction

	logic [3:0]          state_q;
	logic [REQ_W-1:0]    size_q;
	logic [CLS_W-1:0]    c_q;
	logic [SLOT_W-1:0]   s_q;
	logic [LINK_W-1:0]   cur_q;
	logic [LINK_W-1:0]   h_q;
	logic [LINK_W-1:0]   n_q;
	logic [SPP_LG-1:0]   k_q;
	logic [PG_W-1:0]     pages_q;
	logic [BYTES_W-1:0]  live_q;
	logic [BYTES_W-1:0]  carved_q;
	logic [CFG_W-1:0]    pool_q;
	logic [LINK_W-1:0]   head_q [NUM_CLASSES];
	logic [LINK_W-1:0]   tail_q [NUM_CLASSES];
	logic [ADDR_W-1:0]   res_q;
	status_t             st_q;
	logic                out_valid_q;
	logic [ADDR_W-1:0]   out_addr_q;
	status_t             out_st_q;
	logic [BYTES_W-1:0]  out_live_q;
	logic [BYTES_W-1:0]  out_carved_q;

	logic                next_we, prev_we, size_we;
	logic [SLOT_W-1:0]   next_wa, prev_wa, size_wa, next_ra, prev_ra, size_ra;
	logic [LINK_W-1:0]   next_wd, prev_wd, next_rd, prev_rd;
	logic [SIZE_W:0]     size_wd, size_rd;

	sfla_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_next (
		.clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
		.raddr(next_ra), .rdata(next_rd)
	);
	sfla_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_prev (
		.clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
		.raddr(prev_ra), .rdata(prev_rd)
	);
	sfla_ram #(.WIDTH(SIZE_W + 1), .DEPTH(POOL_SLOTS)) u_size (
		.clk(clk), .we(size_we), .waddr(size_wa), .wdata(size_wd),
		.raddr(size_ra), .rdata(size_rd)
	);

	// request decode
	logic [CLS_W-1:0]  in_cls;
	logic [CLS_IW-1:0] in_ci;
	logic [31:0]       limit;
	logic [31:0]       blk;
	logic              free_bad;
	logic [SLOT_W-1:0] free_slot;

	always_comb begin
		in_cls    = class_of((REQ_W + 1)'(request_size) + (REQ_W + 1)'(HEADER_BYTES));
		in_ci     = in_cls[CLS_IW-1:0];
		limit     = (32'(pool_q) < 32'(POOL_PAGES)) ? 32'(pool_q) : 32'(POOL_PAGES);
		blk       = 32'(payload_address) - 32'(HEADER_BYTES);
		free_bad  = (32'(payload_address) < 32'(HEADER_BYTES))
			|| ((blk & ((32'd1 << MIN_BLOCK_SHIFT) - 32'd1)) != 32'd0)
			|| ((blk >> PAGE_LG) >= 32'(pages_q));
		free_slot = SLOT_W'(blk >> MIN_BLOCK_SHIFT);
	end

	// carve and free helpers
	logic [CLS_IW-1:0] ci;
	logic [31:0]       step;
	logic [31:0]       cslot;
	logic [CLS_W-1:0]  fr_cls;
	logic [SIZE_W-1:0] fr_size;

	always_comb begin
		ci      = c_q[CLS_IW-1:0];
		step    = 32'd1 << c_q;
		cslot   = (32'(pages_q) << SPP_LG) | 32'(k_q);
		fr_size = size_rd[SIZE_W-1:0];
		fr_cls  = class_of((REQ_W + 1)'(fr_size) + (REQ_W + 1)'(HEADER_BYTES));
	end

	// memory ports
	always_comb begin
		next_we = 1'b0;
		prev_we = 1'b0;
		size_we = 1'b0;
		next_wa = s_q;
		prev_wa = s_q;
		size_wa = s_q;
		next_wd = NIL;
		prev_wd = NIL;
		size_wd = {1'b0, SIZE_W'(size_q)};
		next_ra = SLOT_W'(cur_q);
		prev_ra = SLOT_W'(cur_q);
		size_ra = free_slot;
		case (state_q)
			S_CARVE: begin
				size_we = 1'b1;
				size_wa = SLOT_W'(cslot);
				size_wd = '0;
				if ((32'(k_q) & (step - 32'd1)) == 32'd0) begin
					next_we = 1'b1;
					prev_we = 1'b1;
					next_wa = SLOT_W'(cslot);
					prev_wa = SLOT_W'(cslot);
					next_wd = (k_q == '0) ? NIL : LINK_W'(cslot - step);
					prev_wd = (32'(k_q) + step >= 32'(SPP)) ? NIL : LINK_W'(cslot + step);
				end
			end
			S_POP_RD: begin
				next_ra = SLOT_W'(head_q[ci]);
			end
			S_POP_WR: begin
				size_we = 1'b1;
				size_wd = {1'b1, SIZE_W'(size_q)};
				if (next_rd != NIL) begin
					prev_we = 1'b1;
					prev_wa = SLOT_W'(next_rd);
					prev_wd = NIL;
				end
			end
			S_FREE_CHK: begin
				if (size_rd[SIZE_W]) begin
					size_we = 1'b1;
					size_wd = {1'b0, fr_size};
				end
			end
			S_INS1: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				next_wd = next_rd;
				prev_wd = cur_q;
			end
			S_INS2: begin
				next_we = 1'b1;
				next_wa = SLOT_W'(cur_q);
				next_wd = LINK_W'(s_q);
				if (n_q != NIL) begin
					prev_we = 1'b1;
					prev_wa = SLOT_W'(n_q);
					prev_wd = LINK_W'(s_q);
				end
			end
			S_PUSH1: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				next_wd = head_q[ci];
				prev_wd = NIL;
			end
			S_PUSH2: begin
				prev_we = 1'b1;
				prev_wa = SLOT_W'(h_q);
				prev_wd = LINK_W'(s_q);
			end
			default: begin
			end
		endcase
	end

	assign in_ready        = (state_q == S_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign result_address  = out_addr_q;
	assign status          = out_st_q;
	assign allocated_bytes = out_live_q;
	assign pool_bytes_used = out_carved_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			size_q       <= '0;
			c_q          <= '0;
			s_q          <= '0;
			cur_q        <= '0;
			h_q          <= '0;
			n_q          <= '0;
			k_q          <= '0;
			pages_q      <= '0;
			live_q       <= '0;
			carved_q     <= '0;
			pool_q       <= CFG_POOL_RESET;
			res_q        <= '0;
			st_q         <= ST_OK;
			out_valid_q  <= 1'b0;
			out_addr_q   <= '0;
			out_st_q     <= ST_OK;
			out_live_q   <= '0;
			out_carved_q <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				head_q[i] <= NIL;
				tail_q[i] <= NIL;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				pool_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						size_q  <= request_size;
						res_q   <= '0;
						st_q    <= ST_OK;
						state_q <= S_DONE;
						case (opcode)
							OP_ALLOC: begin
								c_q <= in_cls;
								k_q <= '0;
								if (request_size == '0) begin
									st_q <= ST_ZERO_SIZE;
								end else if (32'(in_cls) >= 32'(NUM_CLASSES)) begin
									st_q <= ST_TOO_LARGE;
								end else if (head_q[in_ci] != NIL) begin
									state_q <= S_POP_RD;
								end else if (32'(pages_q) >= limit) begin
									st_q <= ST_EXHAUSTED;
								end else begin
									state_q <= S_CARVE;
								end
							end
							OP_FREE: begin
								s_q <= free_slot;
								if (payload_address == '0) begin
									st_q <= ST_NULL_FREE;
								end else if (free_bad) begin
									st_q <= ST_BAD_ADDR;
								end else begin
									state_q <= S_FREE_CHK;
								end
							end
							OP_CLEAR: begin
								pages_q  <= '0;
								live_q   <= '0;
								carved_q <= '0;
								for (int i = 0; i < NUM_CLASSES; i++) begin
									head_q[i] <= NIL;
									tail_q[i] <= NIL;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_CARVE: begin
					k_q <= k_q + 1'b1;
					if (32'(k_q) == 32'(SPP - 1)) begin
						head_q[ci] <= LINK_W'((32'(pages_q) << SPP_LG) + 32'(SPP) - step);
						tail_q[ci] <= LINK_W'(32'(pages_q) << SPP_LG);
						pages_q    <= pages_q + 1'b1;
						carved_q   <= carved_q + BYTES_W'(PAGE_SIZE);
						state_q    <= S_POP_RD;
					end
				end
				S_POP_RD: begin
					s_q     <= SLOT_W'(head_q[ci]);
					state_q <= S_POP_WR;
				end
				S_POP_WR: begin
					head_q[ci] <= next_rd;
					if (next_rd == NIL) begin
						tail_q[ci] <= NIL;
					end
					live_q  <= live_q + BYTES_W'(size_q);
					res_q   <= ADDR_W'((32'(s_q) << MIN_BLOCK_SHIFT) + 32'(HEADER_BYTES));
					state_q <= S_DONE;
				end
				S_FREE_CHK: begin
					c_q <= fr_cls;
					if (!size_rd[SIZE_W]) begin
						st_q    <= ST_BAD_ADDR;
						state_q <= S_DONE;
					end else begin
						live_q <= live_q - BYTES_W'(fr_size);
						if (32'(fr_cls) >= 32'(NUM_CLASSES)) begin
							state_q <= S_DONE;
						end else if (tail_q[fr_cls[CLS_IW-1:0]] == NIL) begin
							state_q <= S_PUSH1;
						end else begin
							cur_q   <= tail_q[fr_cls[CLS_IW-1:0]];
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					state_q <= (cur_q > LINK_W'(s_q)) ? S_WALK_PREV : S_INS1;
				end
				S_WALK_PREV: begin
					if (prev_rd == NIL) begin
						state_q <= S_PUSH1;
					end else begin
						cur_q   <= prev_rd;
						state_q <= S_WALK;
					end
				end
				S_INS1: begin
					n_q     <= next_rd;
					state_q <= S_INS2;
				end
				S_INS2: begin
					if (n_q == NIL) begin
						tail_q[ci] <= LINK_W'(s_q);
					end
					state_q <= S_DONE;
				end
				S_PUSH1: begin
					h_q        <= head_q[ci];
					head_q[ci] <= LINK_W'(s_q);
					if (head_q[ci] == NIL) begin
						tail_q[ci] <= LINK_W'(s_q);
						state_q    <= S_DONE;
					end else begin
						state_q <= S_PUSH2;
					end
				end
				S_PUSH2: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_addr_q   <= res_q;
						out_st_q     <= st_q;
						out_live_q   <= live_q;
						out_carved_q <= carved_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

@@ tb/segregated_free_list_allocator_tb.sv @@
// Self-checking testbench for the segregated free list allocator: directed and random requests.
`timescale 1ns / 1ps
module segregated_free_list_allocator_tb;
	import sfla_pkg::*;

	localparam int POOL_PAGES = 64;
	localparam int NCLS       = 8;
	localparam int PAGE       = 4096;
	localparam int HDR        = 16;
	localparam int SHIFT      = 5;
	localparam int SLOTS_PG   = PAGE >> SHIFT;
	localparam int NSLOTS     = POOL_PAGES * SLOTS_PG;
	localparam int NIL        = NSLOTS;

	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		status_t            st;
		logic [BYTES_W-1:0] live;
		logic [BYTES_W-1:0] carved;
	} alloc_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	opcode_t opcode = OP_ALLOC;
	logic [REQ_W-1:0] request_size = '0;
	logic [ADDR_W-1:0] payload_address = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ADDR_W-1:0] result_address;
	status_t status;
	logic [BYTES_W-1:0] allocated_bytes;
	logic [BYTES_W-1:0] pool_bytes_used;

	segregated_free_list_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.request_size(request_size), .payload_address(payload_address),
		.out_valid(out_valid), .out_ready(out_ready), .result_address(result_address),
		.status(status), .allocated_bytes(allocated_bytes), .pool_bytes_used(pool_bytes_used)
	);

	always #6 clk = ~clk;

	// allocator model state
	int unsigned nxt [NSLOTS];
	int unsigned prv [NSLOTS];
	int unsigned req_sz [NSLOTS];
	bit slot_busy [NSLOTS];
	int unsigned head [NCLS];
	int unsigned tail [NCLS];
	int unsigned pages_used;
	int unsigned live_total;
	int unsigned carved_total;
	int unsigned page_limit = 64;

	alloc_result_t pending_results[$];
	int unsigned live_payloads[$];
	int errors = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int stall_left = 0;

	function automatic int class_for(int unsigned sz);
		int unsigned need;
		int c;
		need = sz + HDR;
		c = 0;
		while (c < NCLS && need > (1 << (SHIFT + c))) c++;
		if (c < NCLS && (1 << (SHIFT + c)) > PAGE) c = NCLS;
		return c;
	endfunction

	function automatic void wipe_lists();
		for (int c = 0; c < NCLS; c++) begin
			head[c] = NIL;
			tail[c] = NIL;
		end
		for (int s = 0; s < NSLOTS; s++) slot_busy[s] = 0;
		pages_used = 0;
		live_total = 0;
		carved_total = 0;
		live_payloads.delete();
	endfunction

	function automatic void push_front(int c, int unsigned s);
		int unsigned h;
		h = head[c];
		prv[s] = NIL;
		nxt[s] = h;
		if (h == NIL) tail[c] = s;
		else prv[h] = s;
		head[c] = s;
	endfunction

	function automatic void sorted_insert(int c, int unsigned s);
		int unsigned cur;
		int unsigned n;
		cur = tail[c];
		if (cur == NIL) begin
			push_front(c, s);
			return;
		end
		while (cur > s) begin
			if (prv[cur] == NIL) begin
				push_front(c, s);
				return;
			end
			cur = prv[cur];
		end
		n = nxt[cur];
		prv[s] = cur;
		nxt[s] = n;
		nxt[cur] = s;
		if (n == NIL) tail[c] = s;
		else prv[n] = s;
	endfunction

	function automatic void predict_request(opcode_t op, int unsigned sz, int unsigned pa);
		alloc_result_t r;
		int c;
		int unsigned s;
		int unsigned n;
		int unsigned lim;
		r = '0;
		r.st = ST_OK;
		if (op == OP_ALLOC) begin
			c = class_for(sz);
			lim = page_limit < POOL_PAGES ? page_limit : POOL_PAGES;
			if (sz == 0) r.st = ST_ZERO_SIZE;
			else if (c >= NCLS) r.st = ST_TOO_LARGE;
			else if (head[c] == NIL && pages_used >= lim) r.st = ST_EXHAUSTED;
			else begin
				if (head[c] == NIL) begin
					for (int k = 0; k < SLOTS_PG; k += (1 << c))
						push_front(c, pages_used * SLOTS_PG + k);
					pages_used++;
					carved_total += PAGE;
				end
				s = head[c];
				n = nxt[s];
				head[c] = n;
				if (n == NIL) tail[c] = NIL;
				else prv[n] = NIL;
				slot_busy[s] = 1;
				req_sz[s] = sz;
				live_total += sz;
				r.addr = ADDR_W'((s << SHIFT) + HDR);
				live_payloads.push_back(32'(r.addr));
			end
		end else if (op == OP_FREE) begin
			s = (pa - HDR) >> SHIFT;
			if (pa == 0) r.st = ST_NULL_FREE;
			else if (pa < HDR || ((pa - HDR) & ((1 << SHIFT) - 1)) != 0 || s >= NSLOTS
					|| !slot_busy[s])
				r.st = ST_BAD_ADDR;
			else begin
				slot_busy[s] = 0;
				live_total -= req_sz[s];
				c = class_for(req_sz[s]);
				if (c < NCLS) sorted_insert(c, s);
				foreach (live_payloads[i])
					if (live_payloads[i] == pa) begin
						live_payloads.delete(i);
						break;
					end
			end
		end else if (op == OP_CLEAR) begin
			wipe_lists();
		end
		r.live = BYTES_W'(live_total);
		r.carved = BYTES_W'(carved_total);
		pending_results.push_back(r);
	endfunction

	task automatic send_request(opcode_t op, int unsigned sz, int unsigned pa);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		request_size <= REQ_W'(sz);
		payload_address <= ADDR_W'(pa);
		do @(posedge clk); while (!in_ready);
		predict_request(op, sz, pa);
	endtask

	task automatic drain_and_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_pool_pages(int unsigned v);
		drain_and_idle();
		cfg_valid <= 1'b1;
		cfg_data <= CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		page_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_request();
		int unsigned pick;
		int unsigned sz;
		pick = $urandom_range(99);
		case ($urandom_range(9))
			0, 1, 2, 3: sz = $urandom_range(1, 48);
			4, 5, 6: sz = $urandom_range(1, 500);
			7: sz = $urandom_range(1, 4080);
			8: sz = $urandom_range(4000, 4200);
			default: sz = $urandom;
		endcase
		sz &= 20'hFFFFF;
		if (pick < 50) send_request(OP_ALLOC, sz, $urandom & 18'h3FFFF);
		else if (pick < 85 && live_payloads.size() > 0)
			send_request(OP_FREE, sz, live_payloads[$urandom_range(live_payloads.size() - 1)]);
		else if (pick < 92) send_request(OP_FREE, sz, $urandom & 18'h3FFFF);
		else if (pick < 94) send_request(OP_FREE, sz, 0);
		else if (pick < 96) send_request(OP_ALLOC, 0, $urandom & 18'h3FFFF);
		else if (pick < 98) send_request(OP_RESERVED, sz, $urandom & 18'h3FFFF);
		else send_request(OP_CLEAR, sz, $urandom & 18'h3FFFF);
	endtask

	task automatic test_directed();
		int unsigned a;
		send_request(OP_ALLOC, 1, 0);
		a = live_payloads[$];
		send_request(OP_ALLOC, 16, 0);
		send_request(OP_ALLOC, 17, 0);
		send_request(OP_ALLOC, 4080, 0);
		send_request(OP_ALLOC, 4081, 0);
		send_request(OP_ALLOC, 0, 18'h3FFFF);
		send_request(OP_ALLOC, 20'hFFFFF, 0);
		send_request(OP_FREE, 0, 0);
		send_request(OP_FREE, 20'hFFFFF, 8);
		send_request(OP_FREE, 0, 49);
		send_request(OP_FREE, 0, 18'h3FFFF);
		send_request(OP_FREE, 0, 18'h3FFF0);
		send_request(OP_FREE, 0, a);
		send_request(OP_FREE, 0, a);
		send_request(OP_RESERVED, 20'hAAAAA, 18'h15555);
		send_request(OP_CLEAR, 0, 0);
		send_request(OP_FREE, 0, 48);
	endtask

	task automatic test_pool_limits();
		write_pool_pages(1);
		send_request(OP_ALLOC, 4080, 0);
		send_request(OP_ALLOC, 4080, 0);
		send_request(OP_ALLOC, 20, 0);
		send_request(OP_CLEAR, 0, 0);
		write_pool_pages(0);
		send_request(OP_ALLOC, 5, 0);
		write_pool_pages(127);
	endtask

	task automatic test_random(int sidle, int ridle, int n, int unsigned pages);
		write_pool_pages(pages);
		send_idle = sidle;
		recv_idle = ridle;
		repeat (n) send_random_request();
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_idle = 0;
		stall_left = 500;
		repeat (40) send_random_request();
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{result_address, status, allocated_bytes, pool_bytes_used};
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= 10)
						$display({"mismatch: exp addr %0d st %0d live %0d pool %0d,",
							" got addr %0d st %0d live %0d pool %0d"},
							want.addr, want.st, want.live, want.carved,
							got.addr, got.st, got.live, got.carved);
				end
			end
		end
	end

	initial begin
		wipe_lists();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_pool_limits();
		test_random(25, 74, 240, 64);
		test_random(74, 25, 240, 37);
		test_random(0, 0, 240, 64);
		test_backpressure();
		drain_and_idle();
		if (errors == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#60_000_000;
		$display("FAILURE");
		$finish;
	end
endmodule
